@@ hw/rtl/tpq_pkg.sv @@
// Package for the tree path min/max query block.
// Holds sizes, item and table entry types, request codes, controller states and
// datapath commands. Depends on nothing.
package tpq_pkg;

  localparam int MAX_NODES   = 1024;
  localparam int LIFT_LEVELS = 10;
  localparam int WEIGHT_BITS = 20;

  localparam int NODE_W     = 11;
  localparam int LVL_W      = (LIFT_LEVELS > 1) ? $clog2(LIFT_LEVELS) : 1;
  localparam int EDGE_DEPTH = MAX_NODES - 1;
  localparam int FILL_W     = $clog2(MAX_NODES);
  localparam int QIX_W      = $clog2(MAX_NODES);
  localparam int QCNT_W     = QIX_W + 1;
  localparam int NODE_SLOTS = MAX_NODES + 1;
  localparam int TBL_DEPTH  = LIFT_LEVELS * NODE_SLOTS;
  localparam int TBL_AW     = $clog2(TBL_DEPTH);

  localparam logic [1:0] REQ_LOAD  = 2'd0;
  localparam logic [1:0] REQ_BUILD = 2'd1;
  localparam logic [1:0] REQ_QUERY = 2'd2;

  typedef struct packed {
    logic [1:0]             req_type;
    logic [NODE_W-1:0]      node_a;
    logic [NODE_W-1:0]      node_b;
    logic [WEIGHT_BITS-1:0] weight;
  } req_item_t;

  typedef struct packed {
    logic [WEIGHT_BITS-1:0] path_min;
    logic [WEIGHT_BITS-1:0] path_max;
  } rsp_item_t;

  typedef struct packed {
    logic [NODE_W-1:0]      a;
    logic [NODE_W-1:0]      b;
    logic [WEIGHT_BITS-1:0] w;
  } edge_t;

  typedef struct packed {
    logic [NODE_W-1:0]      anc;
    logic [WEIGHT_BITS-1:0] wmin;
    logic [WEIGHT_BITS-1:0] wmax;
  } tbl_entry_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_BSTART, OP_CLR, OP_ROOT, OP_POP, OP_CUR, OP_DCUR,
    OP_ERD, OP_ECHK, OP_EUPD, OP_LSTART, OP_LRD1, OP_LRD2, OP_LWR,
    OP_QSTART, OP_QDA, OP_QDB, OP_QSW, OP_P1RD, OP_P1SKIP, OP_P1TAKE,
    OP_P2INIT, OP_P2RA, OP_P2RB, OP_P2CMP, OP_FRA, OP_FRB, OP_FTAKE
  } dp_op_t;

  typedef enum logic [4:0] {
    S_IDLE, S_CLR, S_ROOT, S_BFS, S_POP, S_CUR, S_DCUR, S_ERD, S_ECHK, S_EUPD,
    S_LSTART, S_LRD1, S_LRD2, S_LWR, S_QDA, S_QDB, S_QSW, S_P1, S_P1T,
    S_P2S, S_P2A, S_P2B, S_P2C, S_F0, S_F1, S_F2, S_QOUT
  } state_t;

  typedef struct packed {
    dp_op_t op;
    logic   out_load;
  } tpq_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic q_empty;
    logic no_edges;
    logic e_last;
    logic lvl_last;
    logic q_fail;
    logic diff_bit;
    logic lvl_zero;
    logic ab_eq;
  } tpq_stat_t;

  // Table row for a lift level and node: level * (MAX_NODES + 1) + node.
  function automatic logic [TBL_AW-1:0] tbl_addr(input logic [LVL_W-1:0] lvl,
                                                 input logic [NODE_W-1:0] node);
    tbl_addr = TBL_AW'(lvl) * TBL_AW'(NODE_SLOTS) + TBL_AW'(node);
  endfunction

  function automatic logic [WEIGHT_BITS-1:0] min2(input logic [WEIGHT_BITS-1:0] x,
                                                  input logic [WEIGHT_BITS-1:0] y);
    min2 = (x < y) ? x : y;
  endfunction

  function automatic logic [WEIGHT_BITS-1:0] max2(input logic [WEIGHT_BITS-1:0] x,
                                                  input logic [WEIGHT_BITS-1:0] y);
    max2 = (x > y) ? x : y;
  endfunction

endpackage

@@ hw/rtl/tpq_ctrl.sv @@
// Controller state machine for the tree path min/max query block.
// Sequences loads, table builds and queries by commands to tpq_dp.
// Depends on tpq_pkg.
module tpq_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  input  logic [1:0]          req_type,
  input  logic                out_free,
  input  tpq_pkg::tpq_stat_t  stat,
  output logic                req_ready,
  output tpq_pkg::tpq_cmd_t   cmd
);

  tpq_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tpq_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    cmd.op       = tpq_pkg::OP_NONE;
    cmd.out_load = 1'b0;
    req_ready    = 1'b0;
    case (state)
      tpq_pkg::S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          case (req_type)
            tpq_pkg::REQ_LOAD: cmd.op = tpq_pkg::OP_LOAD;
            tpq_pkg::REQ_BUILD: begin
              cmd.op     = tpq_pkg::OP_BSTART;
              state_next = tpq_pkg::S_CLR;
            end
            tpq_pkg::REQ_QUERY: begin
              cmd.op     = tpq_pkg::OP_QSTART;
              state_next = tpq_pkg::S_QDA;
            end
            default: cmd.op = tpq_pkg::OP_NONE;
          endcase
        end
      end
      tpq_pkg::S_CLR: begin
        cmd.op = tpq_pkg::OP_CLR;
        if (stat.clr_last) state_next = tpq_pkg::S_ROOT;
      end
      tpq_pkg::S_ROOT: begin
        cmd.op     = tpq_pkg::OP_ROOT;
        state_next = tpq_pkg::S_BFS;
      end
      tpq_pkg::S_BFS: begin
        if (!stat.q_empty) begin
          state_next = tpq_pkg::S_POP;
        end else if (tpq_pkg::LIFT_LEVELS > 1) begin
          state_next = tpq_pkg::S_LSTART;
        end else begin
          state_next = tpq_pkg::S_IDLE;
        end
      end
      tpq_pkg::S_POP: begin
        cmd.op     = tpq_pkg::OP_POP;
        state_next = tpq_pkg::S_CUR;
      end
      tpq_pkg::S_CUR: begin
        cmd.op     = tpq_pkg::OP_CUR;
        state_next = tpq_pkg::S_DCUR;
      end
      tpq_pkg::S_DCUR: begin
        cmd.op     = tpq_pkg::OP_DCUR;
        state_next = stat.no_edges ? tpq_pkg::S_BFS : tpq_pkg::S_ERD;
      end
      tpq_pkg::S_ERD: begin
        cmd.op     = tpq_pkg::OP_ERD;
        state_next = tpq_pkg::S_ECHK;
      end
      tpq_pkg::S_ECHK: begin
        cmd.op     = tpq_pkg::OP_ECHK;
        state_next = tpq_pkg::S_EUPD;
      end
      tpq_pkg::S_EUPD: begin
        cmd.op     = tpq_pkg::OP_EUPD;
        state_next = stat.e_last ? tpq_pkg::S_BFS : tpq_pkg::S_ERD;
      end
      tpq_pkg::S_LSTART: begin
        cmd.op     = tpq_pkg::OP_LSTART;
        state_next = tpq_pkg::S_LRD1;
      end
      tpq_pkg::S_LRD1: begin
        cmd.op     = tpq_pkg::OP_LRD1;
        state_next = tpq_pkg::S_LRD2;
      end
      tpq_pkg::S_LRD2: begin
        cmd.op     = tpq_pkg::OP_LRD2;
        state_next = tpq_pkg::S_LWR;
      end
      tpq_pkg::S_LWR: begin
        cmd.op     = tpq_pkg::OP_LWR;
        state_next = stat.lvl_last ? tpq_pkg::S_IDLE : tpq_pkg::S_LRD1;
      end
      tpq_pkg::S_QDA: begin
        cmd.op     = tpq_pkg::OP_QDA;
        state_next = tpq_pkg::S_QDB;
      end
      tpq_pkg::S_QDB: begin
        cmd.op     = tpq_pkg::OP_QDB;
        state_next = tpq_pkg::S_QSW;
      end
      tpq_pkg::S_QSW: begin
        cmd.op     = tpq_pkg::OP_QSW;
        state_next = tpq_pkg::S_P1;
      end
      tpq_pkg::S_P1: begin
        if (stat.q_fail) begin
          state_next = tpq_pkg::S_QOUT;
        end else if (stat.diff_bit) begin
          cmd.op     = tpq_pkg::OP_P1RD;
          state_next = tpq_pkg::S_P1T;
        end else begin
          cmd.op = tpq_pkg::OP_P1SKIP;
          if (stat.lvl_zero) state_next = tpq_pkg::S_P2S;
        end
      end
      tpq_pkg::S_P1T: begin
        cmd.op     = tpq_pkg::OP_P1TAKE;
        state_next = stat.lvl_zero ? tpq_pkg::S_P2S : tpq_pkg::S_P1;
      end
      tpq_pkg::S_P2S: begin
        cmd.op     = tpq_pkg::OP_P2INIT;
        state_next = stat.ab_eq ? tpq_pkg::S_QOUT : tpq_pkg::S_P2A;
      end
      tpq_pkg::S_P2A: begin
        cmd.op     = tpq_pkg::OP_P2RA;
        state_next = tpq_pkg::S_P2B;
      end
      tpq_pkg::S_P2B: begin
        cmd.op     = tpq_pkg::OP_P2RB;
        state_next = tpq_pkg::S_P2C;
      end
      tpq_pkg::S_P2C: begin
        cmd.op     = tpq_pkg::OP_P2CMP;
        state_next = stat.lvl_zero ? tpq_pkg::S_F0 : tpq_pkg::S_P2A;
      end
      tpq_pkg::S_F0: begin
        cmd.op     = tpq_pkg::OP_FRA;
        state_next = tpq_pkg::S_F1;
      end
      tpq_pkg::S_F1: begin
        cmd.op     = tpq_pkg::OP_FRB;
        state_next = tpq_pkg::S_F2;
      end
      tpq_pkg::S_F2: begin
        cmd.op     = tpq_pkg::OP_FTAKE;
        state_next = tpq_pkg::S_QOUT;
      end
      tpq_pkg::S_QOUT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = tpq_pkg::S_IDLE;
        end
      end
      default: state_next = tpq_pkg::S_IDLE;
    endcase
  end

endmodule

@@ hw/rtl/tpq_dp.sv @@
// Datapath for the tree path min/max query block: edge store, search queue,
// depth memory, lifting table memory and the query registers.
// Depends on tpq_pkg; driven by commands from tpq_ctrl.
module tpq_dp (
  input  logic                                 clk,
  input  logic                                 rst,
  input  tpq_pkg::tpq_cmd_t                    cmd,
  input  tpq_pkg::req_item_t                   item,
  input  logic                                 cfg_wr_en,
  input  logic [tpq_pkg::NODE_W-1:0]           cfg_wr_data,
  output tpq_pkg::tpq_stat_t                   stat,
  output tpq_pkg::rsp_item_t                   res
);

  localparam int NW = tpq_pkg::NODE_W;
  localparam int WB = tpq_pkg::WEIGHT_BITS;
  localparam int LW = tpq_pkg::LVL_W;

  tpq_pkg::edge_t      edge_mem [0:tpq_pkg::EDGE_DEPTH-1];
  logic [NW-1:0]       queue_mem [0:tpq_pkg::MAX_NODES-1];
  logic [NW-1:0]       depth_mem [0:tpq_pkg::NODE_SLOTS-1];
  tpq_pkg::tbl_entry_t tbl_mem [0:tpq_pkg::TBL_DEPTH-1];

  tpq_pkg::edge_t      edge_q;
  logic [NW-1:0]       queue_q;
  logic [NW-1:0]       depth_q;
  tpq_pkg::tbl_entry_t tbl_q;

  logic [NW-1:0]                  node_count;
  logic [tpq_pkg::FILL_W-1:0]     fill;
  logic                           built;
  logic [tpq_pkg::TBL_AW-1:0]     cnt;
  logic [tpq_pkg::QCNT_W-1:0]     head, tail;
  logic [NW-1:0]                  cur, dcur, other;
  logic [tpq_pkg::FILL_W-1:0]     e;
  logic [WB-1:0]                  ew;
  logic                           hit;
  logic [LW-1:0]                  p;
  logic [NW-1:0]                  n;
  logic [WB-1:0]                  m2, x2;
  logic [NW-1:0]                  qa, qb, da;
  logic                           bad, fail;
  logic [tpq_pkg::LIFT_LEVELS-1:0] diff;
  logic [LW-1:0]                  lvl;
  logic [WB-1:0]                  mn, mx;
  tpq_pkg::tbl_entry_t            ta;

  logic [NW-1:0] other_c, depth_ra, dep_wa, dep_wd, cfg_sat, dnew;
  logic          hit_c, dep_we, q_we, tbl_we, tbl_re, new_node;
  logic [tpq_pkg::QIX_W-1:0]  q_wa;
  logic [NW-1:0]              q_wd;
  logic [tpq_pkg::TBL_AW-1:0] tbl_wa, tbl_ra;
  tpq_pkg::tbl_entry_t        tbl_wd;

  // Edge check: an edge touches the current node and both ends are in use.
  always_comb begin
    other_c = (edge_q.a == cur) ? edge_q.b : edge_q.a;
    hit_c   = (edge_q.a != '0) && (edge_q.a <= node_count) &&
              (edge_q.b != '0) && (edge_q.b <= node_count) &&
              ((edge_q.a == cur) || (edge_q.b == cur));
  end

  assign new_node = hit && (depth_q == '0);
  assign dnew     = (da > depth_q) ? (da - depth_q) : (depth_q - da);

  always_comb begin
    if (cfg_wr_data < NW'(2)) begin
      cfg_sat = NW'(2);
    end else if (cfg_wr_data > NW'(tpq_pkg::MAX_NODES)) begin
      cfg_sat = NW'(tpq_pkg::MAX_NODES);
    end else begin
      cfg_sat = cfg_wr_data;
    end
  end

  // Memory port selection.
  always_comb begin
    depth_ra = qa;
    dep_we   = 1'b0;
    dep_wa   = cnt[NW-1:0];
    dep_wd   = '0;
    q_we     = 1'b0;
    q_wa     = tail[tpq_pkg::QIX_W-1:0];
    q_wd     = other;
    tbl_we   = 1'b0;
    tbl_wa   = cnt;
    tbl_wd   = '{anc: '0, wmin: '1, wmax: '0};
    tbl_re   = 1'b0;
    tbl_ra   = tpq_pkg::tbl_addr(lvl, qa);
    case (cmd.op)
      tpq_pkg::OP_CLR: begin
        tbl_we = 1'b1;
        dep_we = (cnt <= tpq_pkg::TBL_AW'(tpq_pkg::MAX_NODES));
      end
      tpq_pkg::OP_ROOT: begin
        dep_we = 1'b1;
        dep_wa = NW'(1);
        dep_wd = NW'(1);
        q_we   = 1'b1;
        q_wa   = '0;
        q_wd   = NW'(1);
      end
      tpq_pkg::OP_CUR:  depth_ra = queue_q;
      tpq_pkg::OP_ECHK: depth_ra = other_c;
      tpq_pkg::OP_EUPD: begin
        dep_we = new_node;
        dep_wa = other;
        dep_wd = dcur + NW'(1);
        q_we   = new_node;
        tbl_we = new_node;
        tbl_wa = tpq_pkg::tbl_addr('0, other);
        tbl_wd = '{anc: cur, wmin: ew, wmax: ew};
      end
      tpq_pkg::OP_LRD1: begin
        tbl_re = 1'b1;
        tbl_ra = tpq_pkg::tbl_addr(p - LW'(1), n);
      end
      tpq_pkg::OP_LRD2: begin
        tbl_re = 1'b1;
        tbl_ra = tpq_pkg::tbl_addr(p - LW'(1), tbl_q.anc);
      end
      tpq_pkg::OP_LWR: begin
        tbl_we = 1'b1;
        tbl_wa = tpq_pkg::tbl_addr(p, n);
        tbl_wd = '{anc: tbl_q.anc, wmin: tpq_pkg::min2(tbl_q.wmin, m2),
                   wmax: tpq_pkg::max2(tbl_q.wmax, x2)};
      end
      tpq_pkg::OP_QDA: depth_ra = qa;
      tpq_pkg::OP_QDB: depth_ra = qb;
      tpq_pkg::OP_P1RD, tpq_pkg::OP_P2RB: begin
        tbl_re = 1'b1;
        tbl_ra = tpq_pkg::tbl_addr(lvl, qb);
      end
      tpq_pkg::OP_P2RA: tbl_re = 1'b1;
      tpq_pkg::OP_FRA: begin
        tbl_re = 1'b1;
        tbl_ra = tpq_pkg::tbl_addr('0, qa);
      end
      tpq_pkg::OP_FRB: begin
        tbl_re = 1'b1;
        tbl_ra = tpq_pkg::tbl_addr('0, qb);
      end
      default: tbl_re = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.op == tpq_pkg::OP_LOAD && fill < tpq_pkg::FILL_W'(tpq_pkg::EDGE_DEPTH)) begin
      edge_mem[fill] <= '{a: item.node_a, b: item.node_b, w: item.weight};
    end
    if (cmd.op == tpq_pkg::OP_ERD) begin
      edge_q <= edge_mem[e];
    end
  end

  always_ff @(posedge clk) begin
    if (q_we) begin
      queue_mem[q_wa] <= q_wd;
    end
    if (cmd.op == tpq_pkg::OP_POP) begin
      queue_q <= queue_mem[head[tpq_pkg::QIX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (dep_we) begin
      depth_mem[dep_wa] <= dep_wd;
    end
    depth_q <= depth_mem[depth_ra];
  end

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl_mem[tbl_wa] <= tbl_wd;
    end
    if (tbl_re) begin
      tbl_q <= tbl_mem[tbl_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= NW'(2);
      fill       <= '0;
      built      <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        node_count <= cfg_sat;
      end
      if (cmd.op == tpq_pkg::OP_LOAD && fill < tpq_pkg::FILL_W'(tpq_pkg::EDGE_DEPTH)) begin
        fill <= fill + tpq_pkg::FILL_W'(1);
      end
      if (cmd.op == tpq_pkg::OP_BSTART) begin
        built <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      tpq_pkg::OP_BSTART: cnt <= '0;
      tpq_pkg::OP_CLR:    cnt <= cnt + tpq_pkg::TBL_AW'(1);
      tpq_pkg::OP_ROOT: begin
        head <= '0;
        tail <= tpq_pkg::QCNT_W'(1);
      end
      tpq_pkg::OP_POP: head <= head + tpq_pkg::QCNT_W'(1);
      tpq_pkg::OP_CUR: begin
        cur <= queue_q;
        e   <= '0;
      end
      tpq_pkg::OP_DCUR: dcur <= depth_q;
      tpq_pkg::OP_ECHK: begin
        other <= other_c;
        ew    <= edge_q.w;
        hit   <= hit_c;
      end
      tpq_pkg::OP_EUPD: begin
        if (new_node) tail <= tail + tpq_pkg::QCNT_W'(1);
        e <= e + tpq_pkg::FILL_W'(1);
      end
      tpq_pkg::OP_LSTART: begin
        p <= LW'(1);
        n <= NW'(1);
      end
      tpq_pkg::OP_LRD2: begin
        m2 <= tbl_q.wmin;
        x2 <= tbl_q.wmax;
      end
      tpq_pkg::OP_LWR: begin
        if (n == node_count) begin
          n <= NW'(1);
          p <= p + LW'(1);
        end else begin
          n <= n + NW'(1);
        end
      end
      tpq_pkg::OP_QSTART: begin
        qa  <= item.node_a;
        qb  <= item.node_b;
        bad <= !built || (item.node_a == '0) || (item.node_a > node_count) ||
               (item.node_b == '0) || (item.node_b > node_count);
        mn  <= '1;
        mx  <= '0;
      end
      tpq_pkg::OP_QDB: da <= depth_q;
      tpq_pkg::OP_QSW: begin
        // Here depth_q holds the depth of the second node; the deeper node goes to qb.
        fail <= bad || (da == '0) || (depth_q == '0);
        if (da > depth_q) begin
          qa <= qb;
          qb <= qa;
        end
        diff <= dnew[tpq_pkg::LIFT_LEVELS-1:0];
        lvl  <= LW'(tpq_pkg::LIFT_LEVELS - 1);
      end
      tpq_pkg::OP_P1SKIP: lvl <= lvl - LW'(1);
      tpq_pkg::OP_P1TAKE: begin
        mn  <= tpq_pkg::min2(mn, tbl_q.wmin);
        mx  <= tpq_pkg::max2(mx, tbl_q.wmax);
        qb  <= tbl_q.anc;
        lvl <= lvl - LW'(1);
      end
      tpq_pkg::OP_P2INIT: lvl <= LW'(tpq_pkg::LIFT_LEVELS - 1);
      tpq_pkg::OP_P2RB, tpq_pkg::OP_FRB: ta <= tbl_q;
      tpq_pkg::OP_P2CMP: begin
        if (ta.anc != tbl_q.anc) begin
          mn <= tpq_pkg::min2(mn, tpq_pkg::min2(ta.wmin, tbl_q.wmin));
          mx <= tpq_pkg::max2(mx, tpq_pkg::max2(ta.wmax, tbl_q.wmax));
          qa <= ta.anc;
          qb <= tbl_q.anc;
        end
        lvl <= lvl - LW'(1);
      end
      tpq_pkg::OP_FTAKE: begin
        mn <= tpq_pkg::min2(mn, tpq_pkg::min2(ta.wmin, tbl_q.wmin));
        mx <= tpq_pkg::max2(mx, tpq_pkg::max2(ta.wmax, tbl_q.wmax));
      end
      default: lvl <= lvl;
    endcase
  end

  always_comb begin
    stat.clr_last = (cnt == tpq_pkg::TBL_AW'(tpq_pkg::TBL_DEPTH - 1));
    stat.q_empty  = (head == tail);
    stat.no_edges = (fill == '0);
    stat.e_last   = (e == fill - tpq_pkg::FILL_W'(1));
    stat.lvl_last = (n == node_count) && (p == LW'(tpq_pkg::LIFT_LEVELS - 1));
    stat.q_fail   = fail;
    stat.diff_bit = diff[lvl];
    stat.lvl_zero = (lvl == '0);
    stat.ab_eq    = (qa == qb);
  end

  assign res = '{path_min: mn, path_max: mx};

endmodule

@@ hw/rtl/tree_path_min_max_query.sv @@
// Top level of the tree path min/max query block: output register, controller
// and datapath. Depends on tpq_pkg, tpq_ctrl and tpq_dp.
//
//   port group   dir   handshake            payload
//   req          in    req_valid/req_ready  tpq_pkg::req_item_t
//   rsp          out   rsp_valid/rsp_ready  tpq_pkg::rsp_item_t
//   cfg          in    cfg_wr_en            cfg_wr_data (node_count)
//
// In a query, every lift step that reads the lifting table memory waits on
// its single read port. A build clears the tables, then for each node of the
// search scans every loaded edge, then fills each lift level for each node.
// Reset needs no clearing pass: queries before the first build answer with
// the empty path. A query result waits in the output register; the next
// item is taken once that result has been loaded there.
module tree_path_min_max_query (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_ready,
  input  tpq_pkg::req_item_t          req,
  output logic                        rsp_valid,
  input  logic                        rsp_ready,
  output tpq_pkg::rsp_item_t          rsp,
  input  logic                        cfg_wr_en,
  input  logic [tpq_pkg::NODE_W-1:0]  cfg_wr_data
);

  tpq_pkg::tpq_cmd_t  cmd;
  tpq_pkg::tpq_stat_t stat;
  tpq_pkg::rsp_item_t res;
  logic               out_free;

  assign out_free = !rsp_valid || rsp_ready;

  tpq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_type  (req.req_type),
    .out_free  (out_free),
    .stat      (stat),
    .req_ready (req_ready),
    .cmd       (cmd)
  );

  tpq_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .item        (req),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .stat        (stat),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.out_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      rsp <= res;
    end
  end

  // A result is never loaded over one that is still waiting.
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!rsp_valid || rsp_ready))
    else $error("result loaded over a waiting item");

  // Results are only loaded while the block is busy with a query.
  a_load_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !req_ready)
    else $error("result loaded while idle");

  // An accepted item never produces a result in the very next cycle.
  a_no_quick: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !cmd.out_load)
    else $error("result loaded right after accept");

endmodule

@@ dv/tb_tree_path_min_max_query.sv @@
// Self-checking testbench for the tree path min/max query block.
// Tests load, build and path query items against a predictor of its own.
// Depends on tpq_pkg and tree_path_min_max_query.
`timescale 1ns / 100ps

module tb_tree_path_min_max_query;

  localparam int MAX_NODES   = tpq_pkg::MAX_NODES;
  localparam int LIFT_LEVELS = tpq_pkg::LIFT_LEVELS;
  localparam int EDGE_DEPTH  = tpq_pkg::EDGE_DEPTH;
  localparam int NODE_W      = tpq_pkg::NODE_W;
  localparam int WEIGHT_BITS = tpq_pkg::WEIGHT_BITS;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam logic [WEIGHT_BITS-1:0] EMPTY_MIN = '1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  tpq_pkg::req_item_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  tpq_pkg::rsp_item_t rsp;
  logic cfg_wr_en = 1'b0;
  logic [NODE_W-1:0] cfg_wr_data = '0;

  tree_path_min_max_query dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Mirror of the block's state.
  int unsigned nodes_in_use;
  int unsigned edge_count;
  logic [NODE_W-1:0] edge_a_m [0:EDGE_DEPTH-1];
  logic [NODE_W-1:0] edge_b_m [0:EDGE_DEPTH-1];
  logic [WEIGHT_BITS-1:0] edge_w_m [0:EDGE_DEPTH-1];
  int unsigned depth_m [0:MAX_NODES];
  int unsigned anc_m [0:MAX_NODES][0:LIFT_LEVELS-1];
  logic [WEIGHT_BITS-1:0] min_m [0:MAX_NODES][0:LIFT_LEVELS-1];
  logic [WEIGHT_BITS-1:0] max_m [0:MAX_NODES][0:LIFT_LEVELS-1];

  tpq_pkg::rsp_item_t pending_paths[$];
  int unsigned mismatches = 0;
  int unsigned send_idle = 0;
  int unsigned recv_idle = 0;
  int unsigned hold_left = 0;

  function automatic void clear_lift_tables();
    for (int n = 0; n <= MAX_NODES; n++) begin
      depth_m[n] = 0;
      for (int l = 0; l < LIFT_LEVELS; l++) begin
        anc_m[n][l] = 0;
        min_m[n][l] = EMPTY_MIN;
        max_m[n][l] = '0;
      end
    end
  endfunction

  function automatic bit node_ok(int unsigned n);
    return n >= 1 && n <= nodes_in_use;
  endfunction

  function automatic void build_lift_tables();
    bit seen [0:MAX_NODES];
    int unsigned order [0:MAX_NODES];
    int unsigned head, tail, cur, other, up;
    clear_lift_tables();
    for (int n = 0; n <= MAX_NODES; n++) seen[n] = 1'b0;
    head = 0;
    tail = 1;
    order[0] = 1;
    seen[1] = 1'b1;
    depth_m[1] = 1;
    while (head < tail) begin
      cur = order[head];
      head++;
      for (int e = 0; e < edge_count; e++) begin
        if (!node_ok(edge_a_m[e]) || !node_ok(edge_b_m[e])) continue;
        if (edge_a_m[e] == cur) other = edge_b_m[e];
        else if (edge_b_m[e] == cur) other = edge_a_m[e];
        else continue;
        if (seen[other] || tail > MAX_NODES) continue;
        seen[other] = 1'b1;
        order[tail] = other;
        tail++;
        depth_m[other] = depth_m[cur] + 1;
        anc_m[other][0] = cur;
        min_m[other][0] = edge_w_m[e];
        max_m[other][0] = edge_w_m[e];
      end
    end
    for (int l = 1; l < LIFT_LEVELS; l++) begin
      for (int n = 1; n <= nodes_in_use; n++) begin
        up = anc_m[n][l-1];
        anc_m[n][l] = anc_m[up][l-1];
        min_m[n][l] = (min_m[up][l-1] < min_m[n][l-1]) ? min_m[up][l-1] : min_m[n][l-1];
        max_m[n][l] = (max_m[up][l-1] > max_m[n][l-1]) ? max_m[up][l-1] : max_m[n][l-1];
      end
    end
  endfunction

  function automatic tpq_pkg::rsp_item_t path_extremes(int unsigned a, int unsigned b);
    tpq_pkg::rsp_item_t r;
    int unsigned t, diff;
    r.path_min = EMPTY_MIN;
    r.path_max = '0;
    if (!node_ok(a) || !node_ok(b)) return r;
    if (depth_m[a] == 0 || depth_m[b] == 0) return r;
    if (depth_m[a] > depth_m[b]) begin
      t = a; a = b; b = t;
    end
    diff = depth_m[b] - depth_m[a];
    for (int l = LIFT_LEVELS - 1; l >= 0; l--) begin
      if ((diff >> l) & 1) begin
        if (min_m[b][l] < r.path_min) r.path_min = min_m[b][l];
        if (max_m[b][l] > r.path_max) r.path_max = max_m[b][l];
        b = anc_m[b][l];
      end
    end
    if (a == b) return r;
    for (int l = LIFT_LEVELS - 1; l >= 0; l--) begin
      if (anc_m[a][l] != anc_m[b][l]) begin
        if (min_m[a][l] < r.path_min) r.path_min = min_m[a][l];
        if (max_m[a][l] > r.path_max) r.path_max = max_m[a][l];
        if (min_m[b][l] < r.path_min) r.path_min = min_m[b][l];
        if (max_m[b][l] > r.path_max) r.path_max = max_m[b][l];
        a = anc_m[a][l];
        b = anc_m[b][l];
      end
    end
    if (min_m[a][0] < r.path_min) r.path_min = min_m[a][0];
    if (max_m[a][0] > r.path_max) r.path_max = max_m[a][0];
    if (min_m[b][0] < r.path_min) r.path_min = min_m[b][0];
    if (max_m[b][0] > r.path_max) r.path_max = max_m[b][0];
    return r;
  endfunction

  function automatic void apply_item(tpq_pkg::req_item_t it);
    case (it.req_type)
      tpq_pkg::REQ_LOAD: begin
        if (edge_count < EDGE_DEPTH) begin
          edge_a_m[edge_count] = it.node_a;
          edge_b_m[edge_count] = it.node_b;
          edge_w_m[edge_count] = it.weight;
          edge_count++;
        end
      end
      tpq_pkg::REQ_BUILD: build_lift_tables();
      tpq_pkg::REQ_QUERY:
        pending_paths = {pending_paths, path_extremes(it.node_a, it.node_b)};
      default: ;
    endcase
  endfunction

  // Called at a rising edge; returns at the edge where the item is accepted.
  task automatic send_item(logic [1:0] kind, int unsigned a, int unsigned b,
                           int unsigned w);
    tpq_pkg::req_item_t it;
    int unsigned gap;
    it.req_type = kind;
    it.node_a = a[NODE_W-1:0];
    it.node_b = b[NODE_W-1:0];
    it.weight = w[WEIGHT_BITS-1:0];
    if ($urandom_range(0, 99) < send_idle) begin
      gap = $urandom_range(1, 4);
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= it;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    apply_item(it);
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    while (pending_paths.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  // A query behind every earlier item proves any build has finished.
  task automatic write_node_count(int unsigned v);
    send_item(tpq_pkg::REQ_QUERY, 1, 1, 0);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v[NODE_W-1:0];
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    v = v & 11'h7FF;
    nodes_in_use = (v < 2) ? 2 : (v > MAX_NODES) ? MAX_NODES : v;
  endtask

  always @(posedge clk) begin
    tpq_pkg::rsp_item_t want;
    if (rsp_valid && rsp_ready) begin
      if (pending_paths.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result min=%h max=%h",
                                       rsp.path_min, rsp.path_max);
      end else begin
        want = pending_paths.pop_front();
        if (rsp.path_min !== want.path_min || rsp.path_max !== want.path_max) begin
          mismatches++;
          if (mismatches <= 10)
            $display("path result: expected min=%h max=%h, got min=%h max=%h",
                     want.path_min, want.path_max, rsp.path_min, rsp.path_max);
        end
      end
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  task automatic test_before_build();
    send_item(tpq_pkg::REQ_QUERY, 1, 2, 0);
    send_item(tpq_pkg::REQ_QUERY, 2, 2, 0);
    send_item(tpq_pkg::REQ_QUERY, 0, 1, 0);
    send_item(REQ_UNUSED, 1, 2, 5);
  endtask

  task automatic test_two_nodes();
    send_item(tpq_pkg::REQ_LOAD, 0, 2, 7);
    send_item(tpq_pkg::REQ_LOAD, 1, 5, 9);
    send_item(tpq_pkg::REQ_LOAD, 2, 1, 20'hFFFFE);
    send_item(tpq_pkg::REQ_BUILD, 0, 0, 0);
    send_item(tpq_pkg::REQ_QUERY, 1, 2, 0);
    send_item(tpq_pkg::REQ_QUERY, 2, 1, 0);
    send_item(tpq_pkg::REQ_QUERY, 1, 1, 0);
    send_item(tpq_pkg::REQ_QUERY, 3, 1, 0);
    send_item(tpq_pkg::REQ_QUERY, 2047, 2, 0);
    send_item(tpq_pkg::REQ_QUERY, 2, 0, 0);
  endtask

  task automatic test_wide_count();
    write_node_count(2047);
    send_item(tpq_pkg::REQ_LOAD, 1, 1024, 0);
    send_item(tpq_pkg::REQ_LOAD, 1024, 3, 20'h5555A);
    send_item(tpq_pkg::REQ_LOAD, 3, 4, 20'hAAAA5);
    send_item(tpq_pkg::REQ_BUILD, 0, 0, 0);
    send_item(tpq_pkg::REQ_QUERY, 4, 2, 0);
    send_item(tpq_pkg::REQ_QUERY, 4, 1024, 0);
    send_item(tpq_pkg::REQ_QUERY, 1000, 1, 0);
    send_item(tpq_pkg::REQ_QUERY, 1025, 4, 0);
    write_node_count(0);
    write_node_count(1);
  endtask

  // One random tree on nodes 1..n, then mostly queries on it.
  task automatic random_tree(int unsigned items);
    int unsigned n, sent, a, b, parent, pick;
    bit chain;
    chain = ($urandom_range(0, 3) == 0);
    n = chain ? 64 : $urandom_range(4, 24);
    write_node_count(n);
    sent = 0;
    for (int i = 2; i <= n; i++) begin
      parent = chain ? i - 1 : $urandom_range(1, i - 1);
      if ($urandom_range(0, 1))
        send_item(tpq_pkg::REQ_LOAD, i, parent, $urandom_range(0, 1048574));
      else
        send_item(tpq_pkg::REQ_LOAD, parent, i, $urandom_range(0, 1048574));
      sent++;
    end
    send_item(tpq_pkg::REQ_BUILD, $urandom, $urandom, $urandom);
    sent++;
    while (sent < items) begin
      pick = $urandom_range(0, 99);
      if (pick < 85) begin
        a = $urandom_range(1, n);
        b = $urandom_range(1, n);
        send_item(tpq_pkg::REQ_QUERY, a, b, $urandom);
      end else if (pick < 92) begin
        send_item(tpq_pkg::REQ_QUERY, $urandom_range(0, 2047), $urandom_range(0, 2047),
                  $urandom);
      end else if (pick < 97) begin
        send_item(REQ_UNUSED, $urandom, $urandom, $urandom);
      end else begin
        send_item(tpq_pkg::REQ_LOAD, $urandom_range(0, 2047), $urandom_range(0, 2047),
                  $urandom_range(0, 1048574));
      end
      sent++;
    end
  endtask

  task automatic test_random_phase(int unsigned s_idle, int unsigned r_idle);
    send_idle = s_idle;
    recv_idle = r_idle;
    random_tree(100);
    random_tree(100);
  endtask

  task automatic test_backpressure();
    send_idle = 0;
    recv_idle = 0;
    hold_left = 400;
    for (int i = 0; i < 40; i++)
      send_item(tpq_pkg::REQ_QUERY, $urandom_range(1, nodes_in_use),
                $urandom_range(1, nodes_in_use), 0);
    drain();
    for (int i = 0; i < 20; i++)
      send_item(tpq_pkg::REQ_QUERY, $urandom_range(1, nodes_in_use),
                $urandom_range(1, nodes_in_use), 0);
  endtask

  initial begin
    clear_lift_tables();
    nodes_in_use = 2;
    edge_count = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_before_build();
    test_two_nodes();
    test_wide_count();
    test_random_phase(21, 81);
    test_random_phase(81, 21);
    test_random_phase(0, 0);
    test_backpressure();
    drain();
    if (mismatches == 0 && pending_paths.size() == 0)
      $display("tree_path_min_max_query: match");
    else
      $display("tree_path_min_max_query: mismatch");
    $finish;
  end

  initial begin
    #(60_000_000);
    $display("tree_path_min_max_query: mismatch");
    $finish;
  end

endmodule
